/* hdl/koes_pkg.sv */
package koes_pkg;

  localparam logic [0:0] REQ_LOAD = 1'b0;
  localparam logic [0:0] REQ_STEP = 1'b1;

  localparam logic [7:0] REG_MASS = 8'd0;
  localparam logic [7:0] REG_STEP = 8'd1;

  // load velocity scaling: round(v * 365.242) = floor((v * 365242 + 500) / 1000)
  // floor(x / 1000) = (x * LD_RECIP) >> 60, exact for every x below 2^50
  localparam logic [31:0] LD_SCALE = 32'd365242;
  localparam logic [63:0] LD_BIAS  = 64'd500;
  localparam logic [63:0] LD_RECIP = ((64'd1 << 60) + 64'd999) / 64'd1000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQ,
    ST_SQ_NX,
    ST_SQRT,
    ST_ADV,
    ST_ADV_WB,
    ST_BASE1,
    ST_BASE2,
    ST_DEN1,
    ST_DEN2,
    ST_NUM0,
    ST_NUM,
    ST_DIV,
    ST_DIV_WAIT,
    ST_LD_MUL,
    ST_LD_DIV,
    ST_LD_HI,
    ST_LD_WAIT,
    ST_DONE
  } state_e;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // {overflow, value} of a 64-bit signed value clamped to 32 bits
  function automatic logic [32:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

/* hdl/kepler_orbit_euler_step.sv */
// Channel  | Dir | Payload (low bits first)
// s_axis   | in  | tdata: pos_x, pos_y, pos_z, vel_x_day, vel_y_day, vel_z_day; tuser: req_type
// m_axis   | out | tdata: out_x, out_y, out_z, out_vx, out_vy, out_vz; tuser: step_error
// cfg      | in  | index 0 central_mass, 1 time_step; data bits [30:0]
//
// A step runs three 35-iteration restoring divisions, the 32-step square root and the
// multi-limb products on one 32x32 multiplier; the divisions are skipped when the radius
// is zero. A load does per axis one scaling product and a two-pass reciprocal multiply
// by 1/1000. One item is in work at a time; s_axis_tready is low from acceptance until
// the item is finished. A result waits in the output register while the next item is
// taken; the block stalls at the end of a step only while the previous result is still
// not taken. Reset clears the state and restores the register defaults; no clearing pass.
module kepler_orbit_euler_step
  import koes_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // pos_x, pos_y, pos_z, vel_x_day, vel_y_day, vel_z_day
  input  logic [0:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,  // out_x, out_y, out_z, out_vx, out_vy, out_vz
  output logic [0:0]   m_axis_tuser,  // step_error
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [63:0] GRAV =
    64'(((64'd394784 << FRAC_BITS) * 64'd2 + 64'd10000) / 64'd20000);
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  state_e state_q, state_d, ret_q, ret_d;
  logic [1:0]   ax_q, ax_d;
  logic [95:0]  ma_q, ma_d;
  logic [31:0]  mb_q, mb_d;
  logic [1:0]   limb_q, limb_d, nl_q, nl_d;
  logic         ph_q, ph_d;
  logic [63:0]  prod_q, prod_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  sv_q, sv_d, res_q, res_d;
  logic [4:0]   sk_q, sk_d;
  logic [31:0]  r_q, r_d;
  logic [95:0]  base_q, base_d, den_q, den_d;
  logic         err_q, err_d;
  logic [30:0]  cm_q, ts_q;
  logic [31:0]  pos_q [3], pos_d [3];
  logic [31:0]  vel_q [3], vel_d [3];
  logic [31:0]  ldv_q [3], ldv_d [3];
  logic [31:0]  snp_q [6], snp_d [6];
  logic [191:0] mdat_q, mdat_d;
  logic         merr_q, merr_d;
  logic         mval_q, mval_d;

  logic         div_start, div_done;
  logic [127:0] div_num;
  logic [96:0]  div_den;
  logic [34:0]  div_quo;

  logic [31:0]  limb;
  logic [63:0]  sq_bit, sq_try, adv_m;
  logic signed [63:0] sval, dv;
  logic [32:0]  sat;

  koes_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    unique case (limb_q)
      2'd0:    limb = ma_q[31:0];
      2'd1:    limb = ma_q[63:32];
      default: limb = ma_q[95:64];
    endcase
  end

  assign sq_bit = 64'd1 << {sk_q, 1'b0};
  assign sq_try = res_q + sq_bit;
  assign adv_m  = (acc_q[63:0] + HALF) >> FRAC_BITS;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    ax_d    = ax_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    limb_d  = limb_q;
    nl_d    = nl_q;
    ph_d    = ph_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    sv_d    = sv_q;
    res_d   = res_q;
    sk_d    = sk_q;
    r_d     = r_q;
    base_d  = base_q;
    den_d   = den_q;
    err_d   = err_q;
    pos_d   = pos_q;
    vel_d   = vel_q;
    ldv_d   = ldv_q;
    snp_d   = snp_q;
    mdat_d  = mdat_q;
    merr_d  = merr_q;
    mval_d  = mval_q && !m_axis_tready;
    div_start = 1'b0;
    div_num   = {acc_q[126:0], 1'b0} + {32'b0, den_q};
    div_den   = {den_q, 1'b0};
    sval      = '0;
    dv        = '0;
    sat       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ax_d = 2'd0;
          if (s_axis_tuser == REQ_STEP) begin
            for (int i = 0; i < 3; i++) begin
              snp_d[i]     = pos_q[i];
              snp_d[3 + i] = vel_q[i];
            end
            err_d   = 1'b0;
            state_d = ST_SQ;
          end else begin
            for (int i = 0; i < 3; i++) begin
              pos_d[i] = s_axis_tdata[32 * i +: 32];
              ldv_d[i] = s_axis_tdata[96 + 32 * i +: 32];
            end
            state_d = ST_LD_MUL;
          end
        end
      end
      ST_MUL: begin
        if (!ph_q) begin
          prod_d = limb * mb_q;
          ph_d   = 1'b1;
        end else begin
          unique case (limb_q)
            2'd0:    acc_d = acc_q + {64'b0, prod_q};
            2'd1:    acc_d = acc_q + {32'b0, prod_q, 32'b0};
            default: acc_d = acc_q + {prod_q, 64'b0};
          endcase
          ph_d   = 1'b0;
          limb_d = limb_q + 2'd1;
          if (limb_q == nl_q) begin
            state_d = ret_q;
          end
        end
      end
      ST_SQ: begin
        ma_d  = {64'b0, mag32(pos_q[ax_q])};
        mb_d  = mag32(pos_q[ax_q]);
        nl_d  = 2'd0;
        limb_d = 2'd0;
        ph_d  = 1'b0;
        // keep summing the squares across the three axes
        if (ax_q == 2'd0) begin
          acc_d = '0;
        end
        ret_d   = ST_SQ_NX;
        state_d = ST_MUL;
      end
      ST_SQ_NX: begin
        if (ax_q == 2'd2) begin
          sv_d    = acc_q[63:0];
          res_d   = '0;
          sk_d    = 5'd31;
          state_d = ST_SQRT;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_SQ;
        end
      end
      ST_SQRT: begin
        if (sv_q >= sq_try) begin
          sv_d  = sv_q - sq_try;
          res_d = (res_q >> 1) + sq_bit;
        end else begin
          res_d = res_q >> 1;
        end
        sk_d = sk_q - 5'd1;
        if (sk_q == 5'd0) begin
          r_d     = res_d[31:0];
          ax_d    = 2'd0;
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        ma_d    = {64'b0, mag32(vel_q[ax_q])};
        mb_d    = {1'b0, ts_q};
        nl_d    = 2'd0;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_ADV_WB;
        state_d = ST_MUL;
      end
      ST_ADV_WB: begin
        sval = vel_q[ax_q][31] ? -$signed(adv_m) : $signed(adv_m);
        sat  = sat32(64'($signed(pos_q[ax_q])) + sval);
        pos_d[ax_q] = sat[31:0];
        err_d = err_q | sat[32];
        if (ax_q == 2'd2) begin
          if (r_q == 32'd0) begin
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_BASE1;
          end
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_ADV;
        end
      end
      ST_BASE1: begin
        ma_d    = {32'b0, GRAV};
        mb_d    = {1'b0, ts_q};
        nl_d    = 2'd1;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_BASE2;
        state_d = ST_MUL;
      end
      ST_BASE2: begin
        ma_d    = acc_q[95:0];
        mb_d    = {1'b0, cm_q};
        nl_d    = 2'd2;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_DEN1;
        state_d = ST_MUL;
      end
      ST_DEN1: begin
        base_d  = acc_q[95:0];
        ma_d    = {64'b0, r_q};
        mb_d    = r_q;
        nl_d    = 2'd0;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_DEN2;
        state_d = ST_MUL;
      end
      ST_DEN2: begin
        ma_d    = acc_q[95:0];
        mb_d    = r_q;
        nl_d    = 2'd1;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_NUM0;
        state_d = ST_MUL;
      end
      ST_NUM0: begin
        den_d   = acc_q[95:0];
        ax_d    = 2'd0;
        state_d = ST_NUM;
      end
      ST_NUM: begin
        ma_d    = base_q;
        mb_d    = mag32(pos_q[ax_q]);
        nl_d    = 2'd2;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_DIV;
        state_d = ST_MUL;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_quo > 35'h0_8000_0000) begin
            dv    = 64'sh8000_0000;
            err_d = 1'b1;
          end else begin
            dv = $signed({29'b0, div_quo});
          end
          if (pos_q[ax_q][31]) begin
            dv = -dv;
          end
          sat = sat32(64'($signed(vel_q[ax_q])) - dv);
          vel_d[ax_q] = sat[31:0];
          if (sat[32]) begin
            err_d = 1'b1;
          end
          if (ax_q == 2'd2) begin
            state_d = ST_DONE;
          end else begin
            ax_d    = ax_q + 2'd1;
            state_d = ST_NUM;
          end
        end
      end
      ST_LD_MUL: begin
        ma_d    = {64'b0, mag32(ldv_q[ax_q])};
        mb_d    = LD_SCALE;
        nl_d    = 2'd0;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_LD_DIV;
        state_d = ST_MUL;
      end
      ST_LD_DIV: begin
        // biased magnitude times the low half of the reciprocal
        ma_d    = {32'b0, acc_q[63:0] + LD_BIAS};
        mb_d    = LD_RECIP[31:0];
        nl_d    = 2'd1;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        acc_d   = '0;
        ret_d   = ST_LD_HI;
        state_d = ST_MUL;
      end
      ST_LD_HI: begin
        // add the high half of the reciprocal, one limb up
        ma_d    = {ma_q[63:0], 32'b0};
        mb_d    = LD_RECIP[63:32];
        nl_d    = 2'd2;
        limb_d  = 2'd0;
        ph_d    = 1'b0;
        ret_d   = ST_LD_WAIT;
        state_d = ST_MUL;
      end
      ST_LD_WAIT: begin
        sval = $signed({23'b0, acc_q[100:60]});
        if (ldv_q[ax_q][31]) begin
          sval = -sval;
        end
        sat = sat32(sval);
        vel_d[ax_q] = sat[31:0];
        if (ax_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = ST_LD_MUL;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!mval_q || m_axis_tready) begin
          for (int i = 0; i < 6; i++) begin
            mdat_d[32 * i +: 32] = snp_q[i];
          end
          merr_d  = err_q;
          mval_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      mval_q  <= 1'b0;
      cm_q    <= 31'd1048576;
      ts_q    <= 31'd1048;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      mval_q  <= mval_d;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_MASS) begin
          cm_q <= cfg_data_i[30:0];
        end else if (cfg_index_i == REG_STEP) begin
          ts_q <= cfg_data_i[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    limb_q <= limb_d;
    nl_q   <= nl_d;
    ph_q   <= ph_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    sv_q   <= sv_d;
    res_q  <= res_d;
    sk_q   <= sk_d;
    r_q    <= r_d;
    base_q <= base_d;
    den_q  <= den_d;
    err_q  <= err_d;
    ldv_q  <= ldv_d;
    snp_q  <= snp_d;
    mdat_q <= mdat_d;
    merr_q <= merr_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdat_q;
  assign m_axis_tuser  = merr_q;
  assign cfg_ready_o   = 1'b1;

endmodule

/* hdl/koes_div.sv */
module koes_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [127:0]  num_i,
  input  logic [96:0]   den_i,
  output logic          done_o,
  output logic [34:0]   quo_o
);

  logic [127:0] rem_q, rem_d;
  logic [130:0] ds_q, ds_d;
  logic [34:0]  quo_q, quo_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic         ge;

  // quotient bit 34 flags a quotient of 2^34 or more
  assign ge = {3'b0, rem_q} >= ds_q;

  always_comb begin
    rem_d  = rem_q;
    ds_d   = ds_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      ds_d   = {den_i, 34'b0};
      quo_d  = '0;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - ds_q[127:0];
      end
      quo_d = {quo_q[33:0], ge};
      ds_d  = ds_q >> 1;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    ds_q  <= ds_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
